### sv/tmse_pkg.sv
`default_nettype none
package tmse_pkg;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_UNPRED  = 2'd1,
    ST_NOTIMPL = 2'd2,
    ST_NODEC   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_MRS     = 4'd1,
    OP_MSR     = 4'd2,
    OP_MOVI_T2 = 4'd3,
    OP_MOVW    = 4'd4,
    OP_MOVT    = 4'd5,
    OP_MOVI_T1 = 4'd6,
    OP_MOVR_T1 = 4'd7,
    OP_MOVR_T2 = 4'd8
  } op_t;

  localparam int unsigned NREGS  = 16;
  localparam int unsigned RIDX_W = 4;
  localparam int unsigned FLAG_W = 5;

  localparam logic [RIDX_W-1:0] REG_SP = 4'd13;
  localparam logic [RIDX_W-1:0] REG_PC = 4'd15;

  typedef struct packed {
    logic        mode;
    logic [31:0] instr;
    logic        in_it_block;
    logic        last_in_it_block;
    logic [8:0]  ipsr_value;
    logic [31:0] pc_value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              reg_written;
    logic [RIDX_W-1:0] dest_index;
    logic [31:0]       dest_value;
    logic [FLAG_W-1:0] flags_out;
  } rsp_t;

  function automatic logic bits_match(logic [31:0] w, logic [31:0] ones, logic [31:0] zeros);
    return ((w & ones) == ones) && ((w & zeros) == 32'h0);
  endfunction

  function automatic logic bad_reg(logic [RIDX_W-1:0] r);
    return (r == REG_SP) || (r == REG_PC);
  endfunction

  function automatic op_t decode_op(logic mode, logic [31:0] w);
    logic [31:0] h;
    op_t         op;
    h  = {16'h0, w[15:0]};
    op = OP_NONE;
    if (mode) begin
      if (bits_match(w, 32'hf3ef8000, 32'h0c107000))      op = OP_MRS;
      else if (bits_match(w, 32'hf3808000, 32'h0c707300)) op = OP_MSR;
      else if (bits_match(w, 32'hf04f0000, 32'h0ba08000)) op = OP_MOVI_T2;
      else if (bits_match(w, 32'hf2400000, 32'h09b08000)) op = OP_MOVW;
      else if (bits_match(w, 32'hf2c00000, 32'h09308000)) op = OP_MOVT;
    end else begin
      if (bits_match(h, 32'h00002000, 32'h0000d800))      op = OP_MOVI_T1;
      else if (bits_match(h, 32'h00004600, 32'h0000b900)) op = OP_MOVR_T1;
      else if ((h & 32'h0000ffc0) == 32'h0)               op = OP_MOVR_T2;
    end
    return op;
  endfunction

  // Register-file source for the one read each instruction may need.
  function automatic logic [RIDX_W-1:0] src_index(op_t op, logic [31:0] w);
    logic [RIDX_W-1:0] s;
    unique case (op)
      OP_MSR:     s = w[19:16];
      OP_MOVT:    s = w[11:8];
      OP_MOVR_T1: s = w[6:3];
      OP_MOVR_T2: s = {1'b0, w[5:3]};
      default:    s = '0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

### sv/thumb_move_and_status_execute_core.sv
`default_nettype none
// Channel  | valid        | ready        | payload
// ---------+--------------+--------------+------------------------
// request  | item_valid   | item_ready   | item   (tmse_pkg::req_t)
// result   | result_valid | result_ready | result (tmse_pkg::rsp_t)
//
// One request per cycle while the result side is not stalled.
// Accept edge reads the source register from the synchronous register file;
// when the execute stage advances, it writes the register file and flags and
// loads the output register. A write that lands on the read edge of the next request
// is forwarded. Reset clears the flags and the register-file valid bits.
// A stalled result holds the execute stage, which holds the request side.
module thumb_move_and_status_execute_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire tmse_pkg::req_t item,
  output logic                result_valid,
  input  wire logic           result_ready,
  output tmse_pkg::rsp_t      result
);
  import tmse_pkg::*;

  logic              s1_valid;
  req_t              s1_req;
  logic              s1_adv;
  logic              accept;
  logic [31:0]       rf_rdata;
  logic [FLAG_W-1:0] flags;
  rsp_t              ex_rsp;
  logic              commit;

  assign s1_adv     = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_adv;
  assign accept     = item_valid && item_ready;
  assign commit     = s1_adv && (ex_rsp.status == ST_DONE);

  tmse_rf u_rf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (src_index(decode_op(item.mode, item.instr), item.instr)),
    .rd_data (rf_rdata),
    .wr_en   (commit && ex_rsp.reg_written),
    .wr_addr (ex_rsp.dest_index),
    .wr_data (ex_rsp.dest_value)
  );

  tmse_exec u_exec (
    .req     (s1_req),
    .operand (rf_rdata),
    .flags   (flags),
    .rsp     (ex_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      flags        <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (commit) begin
        flags <= ex_rsp.flags_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req <= item;
    end
    if (s1_adv) begin
      result <= ex_rsp;
    end
  end

  a_wr_only_done: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && ex_rsp.reg_written) |-> (ex_rsp.status == ST_DONE))
    else $error("register write without done status");

  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !commit |=> $stable(flags))
    else $error("flags changed without a completed instruction");

  a_stage_block: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> !item_ready)
    else $error("request taken while execute stage is blocked");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.reg_written) |->
      (result.dest_index == '0 && result.dest_value == 32'h0))
    else $error("destination fields set without a register write");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!s1_valid && !result_valid))
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

### sv/tmse_rf.sv
`default_nettype none
module tmse_rf (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rd_en,
  input  wire logic [tmse_pkg::RIDX_W-1:0] rd_addr,
  output logic [31:0]                     rd_data,
  input  wire logic                       wr_en,
  input  wire logic [tmse_pkg::RIDX_W-1:0] wr_addr,
  input  wire logic [31:0]                wr_data
);
  import tmse_pkg::*;

  logic [31:0]      mem [NREGS];
  logic [NREGS-1:0] vld;
  logic [31:0]      mem_q;
  logic             vld_q;
  logic             fwd_hit;
  logic [31:0]      fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  // Valid bits stand in for the zero reset of the array.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      vld_q   <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q   <= vld[rd_addr];
        fwd_hit <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  // Write landing on the read edge: take the written value.
  assign rd_data = fwd_hit ? fwd_data : (vld_q ? mem_q : 32'h0);

endmodule
`default_nettype wire

### sv/tmse_exec.sv
`default_nettype none
module tmse_exec (
  input  wire tmse_pkg::req_t              req,
  input  wire logic [31:0]                 operand,
  input  wire logic [tmse_pkg::FLAG_W-1:0] flags,
  output tmse_pkg::rsp_t                   rsp
);
  import tmse_pkg::*;

  op_t               op;
  logic [31:0]       w;
  logic [7:0]        sysm;
  logic [4:0]        grp;
  logic [RIDX_W-1:0] rd;
  logic [1:0]        mask;
  logic [11:0]       imm12;
  logic [15:0]       imm16;
  logic [7:0]        b;
  logic [31:0]       rot_src;
  logic [63:0]       rot_dbl;
  logic [31:0]       opnd;
  status_t           st;
  logic              wr;
  logic [RIDX_W-1:0] dst;
  logic [31:0]       val;
  logic [FLAG_W-1:0] nflags;
  logic              c;

  assign w     = req.instr;
  assign op    = decode_op(req.mode, w);
  assign sysm  = w[7:0];
  assign grp   = sysm[7:3];
  assign mask  = w[11:10];
  assign b     = w[7:0];
  assign imm12 = {w[26], w[14:12], w[7:0]};
  assign imm16 = {w[19:16], w[26], w[14:12], w[7:0]};
  assign rot_src = {24'h0, 1'b1, imm12[6:0]};
  assign rot_dbl = {rot_src, rot_src} >> imm12[11:7];
  assign opnd  = (op == OP_MOVR_T1 && w[6:3] == REG_PC) ? req.pc_value : operand;

  always_comb begin
    st     = ST_NODEC;
    wr     = 1'b0;
    rd     = '0;
    val    = 32'h0;
    nflags = flags;
    c      = flags[2];
    unique case (op)
      OP_MRS: begin
        rd = w[11:8];
        if (bad_reg(rd)) begin
          st = ST_UNPRED;
        end else if (grp == 5'd0) begin
          if (sysm[0]) val = val | {23'h0, req.ipsr_value};
          if (!sysm[2]) val = val | {flags, 27'h0};
          st = ST_DONE;
          wr = 1'b1;
        end else if (grp <= 5'd2) begin
          st = ST_NOTIMPL;
        end else begin
          st = ST_UNPRED;
        end
      end
      OP_MSR: begin
        if (mask == 2'd0 || (mask != 2'd2 && sysm > 8'd3)) begin
          st = ST_UNPRED;
        end else if (bad_reg(w[19:16])) begin
          st = ST_UNPRED;
        end else if (grp == 5'd0) begin
          st = ST_DONE;
          if (!sysm[2]) begin
            if (mask[0]) st = ST_UNPRED;
            else nflags = {opnd[31:28], flags[0]};
          end
        end else if (grp <= 5'd2) begin
          st = ST_NOTIMPL;
        end else begin
          st = ST_UNPRED;
        end
      end
      OP_MOVI_T2: begin
        rd = w[11:8];
        st = ST_DONE;
        if (imm12[11:10] == 2'd0) begin
          unique case (imm12[9:8])
            2'd0:    val = {24'h0, b};
            2'd1:    val = {8'h0, b, 8'h0, b};
            2'd2:    val = {b, 8'h0, b, 8'h0};
            default: val = {b, b, b, b};
          endcase
          if (imm12[9:8] != 2'd0 && b == 8'h0) st = ST_UNPRED;
        end else begin
          val = rot_dbl[31:0];
          c   = rot_dbl[31];
        end
        if (st == ST_DONE && bad_reg(rd)) st = ST_UNPRED;
        if (st == ST_DONE) begin
          wr = 1'b1;
          if (w[20]) nflags = {val[31], val == 32'h0, c, flags[1:0]};
        end
      end
      OP_MOVW: begin
        rd = w[11:8];
        if (bad_reg(rd)) begin
          st = ST_UNPRED;
        end else begin
          val = {16'h0, imm16};
          wr  = 1'b1;
          st  = ST_DONE;
        end
      end
      OP_MOVT: begin
        rd = w[11:8];
        if (bad_reg(rd)) begin
          st = ST_UNPRED;
        end else begin
          val = {imm16, opnd[15:0]};
          wr  = 1'b1;
          st  = ST_DONE;
        end
      end
      OP_MOVI_T1: begin
        rd  = {1'b0, w[10:8]};
        val = {24'h0, w[7:0]};
        wr  = 1'b1;
        st  = ST_DONE;
        if (!req.in_it_block) nflags = {val[31], val == 32'h0, flags[2:0]};
      end
      OP_MOVR_T1: begin
        rd = {w[7], w[2:0]};
        if (rd == REG_PC && req.in_it_block && !req.last_in_it_block) begin
          st = ST_UNPRED;
        end else if (rd == REG_PC) begin
          st = ST_NOTIMPL;
        end else begin
          val = opnd;
          wr  = 1'b1;
          st  = ST_DONE;
        end
      end
      OP_MOVR_T2: begin
        if (req.in_it_block) begin
          st = ST_UNPRED;
        end else begin
          rd     = {1'b0, w[2:0]};
          val    = opnd;
          wr     = 1'b1;
          st     = ST_DONE;
          nflags = {val[31], val == 32'h0, flags[2:0]};
        end
      end
      default: begin
        st = ST_NODEC;
      end
    endcase
  end

  // Drop every effect unless the instruction completes.
  always_comb begin
    dst = rd;
    if (st != ST_DONE || !wr) begin
      dst = '0;
    end
    rsp.status      = st;
    rsp.reg_written = (st == ST_DONE) && wr;
    rsp.dest_index  = rsp.reg_written ? dst : '0;
    rsp.dest_value  = rsp.reg_written ? val : 32'h0;
    rsp.flags_out   = (st == ST_DONE) ? nflags : flags;
  end

endmodule
`default_nettype wire

### test/thumb_move_checker.sv
module thumb_move_checker (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  input  wire logic           item_ready,
  input  wire tmse_pkg::req_t item,
  input  wire logic           result_valid,
  input  wire logic           result_ready,
  input  wire tmse_pkg::rsp_t result,
  output int                  mismatches,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import tmse_pkg::*;

  logic [31:0] gpr [16];
  logic [4:0]  psr_flags;
  rsp_t        expected_results [$];

  function automatic logic pattern_hit(logic [31:0] w, logic [31:0] ones, logic [31:0] zeros);
    return ((w & ones) == ones) && ((w & zeros) == 32'h0);
  endfunction

  function automatic logic is_sp_or_pc(logic [3:0] r);
    return (r == 4'd13) || (r == 4'd15);
  endfunction

  function automatic logic [31:0] read_src(logic [3:0] r, logic [31:0] pc);
    return (r == 4'd15) ? pc : gpr[r];
  endfunction

  // N and Z from the value, C given, V and Q held
  function automatic logic [4:0] nz_update(logic [31:0] v, logic c);
    return {v[31], v == 32'h0, c, psr_flags[1:0]};
  endfunction

  function automatic rsp_t execute_move(req_t rq);
    logic [31:0] w, h, val, rv, u;
    logic [63:0] rotated;
    logic [11:0] imm12;
    logic [15:0] imm16;
    logic [7:0]  sysm, b;
    logic [3:0]  rd, rn;
    logic [1:0]  mask;
    logic [4:0]  nflags;
    logic        wr, cout;
    status_t     st;
    rsp_t        r;
    w      = rq.instr;
    h      = {16'h0, w[15:0]};
    st     = ST_NODEC;
    wr     = 1'b0;
    rd     = 4'd0;
    val    = 32'h0;
    nflags = psr_flags;
    sysm   = w[7:0];
    imm16  = {w[19:16], w[26], w[14:12], w[7:0]};
    if (rq.mode) begin
      if (pattern_hit(w, 32'hf3ef8000, 32'h0c107000)) begin
        rd = w[11:8];
        if (is_sp_or_pc(rd)) st = ST_UNPRED;
        else if (sysm[7:3] == 5'd0) begin
          if (sysm[0]) val = val | {23'h0, rq.ipsr_value};
          if (!sysm[2]) val = val | {psr_flags, 27'h0};
          st = ST_DONE;
          wr = 1'b1;
        end else if (sysm[7:3] <= 5'd2) st = ST_NOTIMPL;
        else st = ST_UNPRED;
      end else if (pattern_hit(w, 32'hf3808000, 32'h0c707300)) begin
        mask = w[11:10];
        rn   = w[19:16];
        if (mask == 2'd0 || (mask != 2'd2 && sysm > 8'd3)) st = ST_UNPRED;
        else if (is_sp_or_pc(rn)) st = ST_UNPRED;
        else if (sysm[7:3] == 5'd0) begin
          st = ST_DONE;
          // IPSR/EPSR-only targets write nothing
          if (!sysm[2]) begin
            if (mask[0]) st = ST_UNPRED;
            else begin
              rv     = read_src(rn, rq.pc_value);
              nflags = {rv[31:28], psr_flags[0]};
            end
          end
        end else if (sysm[7:3] <= 5'd2) st = ST_NOTIMPL;
        else st = ST_UNPRED;
      end else if (pattern_hit(w, 32'hf04f0000, 32'h0ba08000)) begin
        imm12 = {w[26], w[14:12], w[7:0]};
        b     = imm12[7:0];
        rd    = w[11:8];
        st    = ST_DONE;
        if (imm12[11:10] == 2'd0) begin
          case (imm12[9:8])
            2'd0:    val = {24'h0, b};
            2'd1:    val = {8'h0, b, 8'h0, b};
            2'd2:    val = {b, 8'h0, b, 8'h0};
            default: val = {b, b, b, b};
          endcase
          if (imm12[9:8] != 2'd0 && b == 8'd0) st = ST_UNPRED;
          cout = psr_flags[2];
        end else begin
          u       = {24'h0, 1'b1, imm12[6:0]};
          rotated = {u, u} >> imm12[11:7];
          val     = rotated[31:0];
          cout    = val[31];
        end
        if (st == ST_DONE && is_sp_or_pc(rd)) st = ST_UNPRED;
        if (st == ST_DONE) begin
          wr = 1'b1;
          if (w[20]) nflags = nz_update(val, cout);
        end
      end else if (pattern_hit(w, 32'hf2400000, 32'h09b08000)) begin
        rd = w[11:8];
        if (is_sp_or_pc(rd)) st = ST_UNPRED;
        else begin
          val = {16'h0, imm16};
          wr  = 1'b1;
          st  = ST_DONE;
        end
      end else if (pattern_hit(w, 32'hf2c00000, 32'h09308000)) begin
        rd = w[11:8];
        if (is_sp_or_pc(rd)) st = ST_UNPRED;
        else begin
          val = {imm16, gpr[rd][15:0]};
          wr  = 1'b1;
          st  = ST_DONE;
        end
      end
    end else begin
      if (pattern_hit(h, 32'h00002000, 32'h0000d800)) begin
        rd  = {1'b0, h[10:8]};
        val = {24'h0, h[7:0]};
        wr  = 1'b1;
        st  = ST_DONE;
        if (!rq.in_it_block) nflags = nz_update(val, psr_flags[2]);
      end else if (pattern_hit(h, 32'h00004600, 32'h0000b900)) begin
        rd = {h[7], h[2:0]};
        if (rd == 4'd15 && rq.in_it_block && !rq.last_in_it_block) st = ST_UNPRED;
        else if (rd == 4'd15) st = ST_NOTIMPL;
        else begin
          val = read_src(h[6:3], rq.pc_value);
          wr  = 1'b1;
          st  = ST_DONE;
        end
      end else if (h[15:6] == 10'h0) begin
        if (rq.in_it_block) st = ST_UNPRED;
        else begin
          rd     = {1'b0, h[2:0]};
          val    = gpr[h[5:3]];
          wr     = 1'b1;
          st     = ST_DONE;
          nflags = nz_update(val, psr_flags[2]);
        end
      end
    end
    // commit only on success
    if (st == ST_DONE) begin
      if (wr) gpr[rd] = val;
      psr_flags = nflags;
    end else begin
      wr = 1'b0;
    end
    if (!wr) begin
      rd  = 4'd0;
      val = 32'h0;
    end
    r.status      = st;
    r.reg_written = wr;
    r.dest_index  = rd;
    r.dest_value  = val;
    r.flags_out   = psr_flags;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0d ns: %s got %h, want %h", $time, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      foreach (gpr[i]) gpr[i] = 32'h0;
      psr_flags = 5'h0;
      expected_results.delete();
      outstanding = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request pending", result.dest_value, 32'h0);
        end else begin
          want = expected_results.pop_front();
          if (result.status !== want.status)
            report_mismatch("status", {30'h0, result.status}, {30'h0, want.status});
          if (result.reg_written !== want.reg_written)
            report_mismatch("reg_written", {31'h0, result.reg_written},
                            {31'h0, want.reg_written});
          if (result.dest_index !== want.dest_index)
            report_mismatch("dest_index", {28'h0, result.dest_index},
                            {28'h0, want.dest_index});
          if (result.dest_value !== want.dest_value)
            report_mismatch("dest_value", result.dest_value, want.dest_value);
          if (result.flags_out !== want.flags_out)
            report_mismatch("flags_out", {27'h0, result.flags_out}, {27'h0, want.flags_out});
        end
      end
      if (item_valid && item_ready) expected_results.push_back(execute_move(item));
      outstanding = expected_results.size();
    end
  end

endmodule

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tmse_pkg::*;

  localparam int RANDOM_REQUESTS = 1250;
  localparam int STALL_LIMIT     = 2000;
  localparam int LONG_HOLD       = 200;

  logic clk          = 1'b0;
  logic rst          = 1'b1;
  logic item_valid   = 1'b0;
  logic item_ready;
  req_t item         = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  rsp_t result;
  bit   no_idle      = 1'b0;
  int   quiet_cycles = 0;
  int   mismatches;
  int   outstanding;

  thumb_move_and_status_execute_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  thumb_move_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic req_t request_of(logic mode, logic [31:0] instr, logic in_it,
                                      logic last_it, logic [8:0] ipsr, logic [31:0] pc);
    req_t r;
    r.mode             = mode;
    r.instr            = instr;
    r.in_it_block      = in_it;
    r.last_in_it_block = last_it;
    r.ipsr_value       = ipsr;
    r.pc_value         = pc;
    return r;
  endfunction

  function automatic req_t rand_request();
    req_t       r;
    int         pick;
    logic [3:0] rd, rn, imm4;
    logic [7:0] sysm, imm8;
    logic [2:0] imm3;
    logic [1:0] mask;
    logic       i_bit, s_bit;
    pick  = $urandom_range(0, 99);
    rd    = 4'($urandom_range(0, 15));
    rn    = 4'($urandom_range(0, 15));
    imm4  = 4'($urandom);
    imm3  = 3'($urandom);
    imm8  = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
    i_bit = 1'($urandom);
    s_bit = 1'($urandom);
    mask  = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'd2;
    // mostly group-zero SYSm, some privileged, some anything
    if ($urandom_range(0, 3) < 2) sysm = 8'($urandom_range(0, 7));
    else if ($urandom_range(0, 1) == 1) sysm = 8'($urandom_range(8, 23));
    else sysm = 8'($urandom);
    r.mode             = 1'b1;
    r.instr            = $urandom;
    r.in_it_block      = ($urandom_range(0, 3) == 0);
    r.last_in_it_block = 1'($urandom);
    r.ipsr_value       = 9'($urandom);
    r.pc_value         = $urandom;
    if (pick < 8) r.instr = {5'b11110, i_bit, 6'b100100, imm4, 1'b0, imm3, rd, imm8};
    else if (pick < 15) r.instr = {5'b11110, i_bit, 6'b101100, imm4, 1'b0, imm3, rd, imm8};
    else if (pick < 27)
      r.instr = {5'b11110, i_bit, 5'b00010, s_bit, 4'hf, 1'b0, imm3, rd, imm8};
    else if (pick < 39) r.instr = {20'hf3ef8, rd, sysm};
    else if (pick < 53) r.instr = {12'hf38, rn, 4'h8, mask, 2'b00, sysm};
    else if (pick < 85) begin
      r.mode = 1'b0;
      if (pick < 63) r.instr[15:0] = {5'b00100, rd[2:0], imm8};
      else if (pick < 75) r.instr[15:0] = {8'h46, rn[0], rd, imm3};
      else r.instr[15:0] = {10'h0, rn[2:0], rd[2:0]};
    end else begin
      r.mode = 1'($urandom);
    end
    return r;
  endfunction

  task automatic send_request(input req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= r;
    do @(posedge clk); while (!(item_valid && item_ready));
  endtask

  // result side: random stalls, one long hold-off to back up the pipe
  initial begin : drain
    int gap;
    int taken;
    taken = 0;
    do @(posedge clk); while (rst);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (taken == 300) gap = LONG_HOLD;
      if (gap != 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
      taken++;
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    req_t corner [$];
    int   n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    corner.push_back(request_of(1'b1, 32'hf64f70ff, 1'b0, 1'b0, 9'h1ff, 32'hffffffff));
    corner.push_back(request_of(1'b1, 32'hf6cf70ff, 1'b0, 1'b0, 9'h000, 32'h00000000));
    corner.push_back(request_of(1'b1, 32'hf3808800, 1'b0, 1'b0, 9'h000, 32'h00000000));
    corner.push_back(request_of(1'b1, 32'hf3ef8100, 1'b0, 1'b0, 9'h000, 32'h00000000));
    corner.push_back(request_of(1'b1, 32'hf3ef8203, 1'b0, 1'b0, 9'h1ff, 32'h00000000));
    corner.push_back(request_of(1'b1, 32'hf3ef8305, 1'b1, 1'b1, 9'h0ab, 32'h12345678));
    corner.push_back(request_of(1'b1, 32'hf3ef8d00, 1'b0, 1'b0, 9'h001, 32'h00000000));
    corner.push_back(request_of(1'b1, 32'hf3ef8408, 1'b0, 1'b0, 9'h001, 32'h00000000));
    corner.push_back(request_of(1'b1, 32'hf3ef84ff, 1'b0, 1'b0, 9'h001, 32'h00000000));
    corner.push_back(request_of(1'b1, 32'hf3808000, 1'b0, 1'b0, 9'h000, 32'h00000000));
    corner.push_back(request_of(1'b1, 32'hf3808400, 1'b0, 1'b0, 9'h000, 32'h00000000));
    corner.push_back(request_of(1'b1, 32'hf3808805, 1'b0, 1'b0, 9'h000, 32'h00000000));
    corner.push_back(request_of(1'b1, 32'hf38d8800, 1'b0, 1'b0, 9'h000, 32'h00000000));
    corner.push_back(request_of(1'b1, 32'hf3808810, 1'b0, 1'b0, 9'h000, 32'h00000000));
    corner.push_back(request_of(1'b1, 32'hf04f1400, 1'b0, 1'b0, 9'h000, 32'h00000000));
    corner.push_back(request_of(1'b1, 32'hf45f75ff, 1'b0, 1'b0, 9'h000, 32'h00000000));
    corner.push_back(request_of(1'b1, 32'hf05f0600, 1'b0, 1'b0, 9'h000, 32'h00000000));
    corner.push_back(request_of(1'b1, 32'hf04f0f01, 1'b0, 1'b0, 9'h000, 32'h00000000));
    corner.push_back(request_of(1'b0, 32'hdead27ff, 1'b0, 1'b0, 9'h000, 32'h00000000));
    corner.push_back(request_of(1'b0, 32'h00002700, 1'b1, 1'b0, 9'h000, 32'h00000000));
    corner.push_back(request_of(1'b0, 32'h00004687, 1'b1, 1'b0, 9'h000, 32'h00000000));
    corner.push_back(request_of(1'b0, 32'h00004687, 1'b1, 1'b1, 9'h000, 32'h00000000));
    corner.push_back(request_of(1'b0, 32'hffff46f8, 1'b0, 1'b0, 9'h000, 32'hfffffffe));
    corner.push_back(request_of(1'b0, 32'h00000001, 1'b0, 1'b0, 9'h000, 32'h00000000));
    corner.push_back(request_of(1'b0, 32'h00000001, 1'b1, 1'b1, 9'h000, 32'h00000000));
    corner.push_back(request_of(1'b1, 32'hffffffff, 1'b1, 1'b1, 9'h1ff, 32'hffffffff));
    corner.push_back(request_of(1'b0, 32'h0000ffff, 1'b0, 1'b0, 9'h000, 32'h00000000));
    foreach (corner[k]) send_request(corner[k]);
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      no_idle = (n >= 500 && n < 650);
      send_request(rand_request());
    end
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
